@@ hw/rtl/tbvpc_pkg.sv @@
// package for the two-button volume press controller
// holds action codes, op codes, register indexes, reset values and shared types
// no dependencies
package tbvpc_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned MsW     = 16;
  localparam int unsigned VolW    = 7;
  localparam int unsigned LoadW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  localparam logic [VolW-1:0] VOL_MAX = VolW'(100);
  localparam logic [VolW-1:0] VOL_MIN = '0;

  localparam logic [MsW-1:0]  MIN_PRESS_RST  = MsW'(50);
  localparam logic [MsW-1:0]  LONG_PRESS_RST = MsW'(800);
  localparam logic [VolW-1:0] STEP_RST       = VolW'(10);
  localparam logic [VolW-1:0] VOLUME_RST     = VolW'(100);

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_SHORT = 2'd1,
    ACT_LONG  = 2'd2
  } action_t;

  typedef enum logic {
    OP_POLL = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_PRESS  = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_STEP       = 2'd2
  } reg_idx_t;

  // press timing thresholds shared by both button trackers
  typedef struct packed {
    logic [MsW-1:0] min_press_ms;
    logic [MsW-1:0] long_hold_ms;
  } press_cfg_t;

endpackage

@@ hw/rtl/two_button_volume_press_controller_core.sv @@
// top level of the two-button volume press controller
// input register, two press trackers and volume logic, result register
// depends on tbvpc_pkg, tbvpc_button, tbvpc_volume
//
// channel  direction  handshake             payload
// in       sink       in_valid / in_ready   op, up_down, down_down, now_ms, load_value
// out      source     out_valid / out_ready volume, volume_written, up_action, down_action
// cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// one transaction per cycle sustained while out_ready keeps the result register moving;
// the input register loads at acceptance and the result register loads from it when
// the pass advances, and out_valid marks the result held there
// the single pass from input register to result register holds the tracker
// compares and volume saturation, and the state updates in that same cycle
// a stalled result register holds the input register, which then stops taking input
// reset (synchronous) clears both pipeline valids, button state, volume to 100
// and the three registers to 50, 800 and 10; cfg_ready is always high
module two_button_volume_press_controller_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             op,
  input  logic                             up_down,
  input  logic                             down_down,
  input  logic [tbvpc_pkg::TimeW-1:0]      now_ms,
  input  logic signed [tbvpc_pkg::LoadW-1:0] load_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tbvpc_pkg::VolW-1:0]       volume,
  output logic                             volume_written,
  output logic [1:0]                       up_action,
  output logic [1:0]                       down_action,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tbvpc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [tbvpc_pkg::CfgDatW-1:0]    cfg_data
);
  import tbvpc_pkg::*;

  // configuration registers
  press_cfg_t      press_cfg;
  logic [VolW-1:0] volume_step;

  // input register
  logic                    s1_valid;
  op_t                     s1_op;
  logic                    s1_up;
  logic                    s1_down;
  logic [TimeW-1:0]        s1_now;
  logic signed [LoadW-1:0] s1_load;

  logic            advance;
  logic            poll_en;
  action_t         up_act;
  action_t         down_act;
  logic [VolW-1:0] volume_next;
  logic            written;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign poll_en   = advance && (s1_op == OP_POLL);

  always_ff @(posedge clk) begin
    if (rst) begin
      press_cfg.min_press_ms <= MIN_PRESS_RST;
      press_cfg.long_hold_ms <= LONG_PRESS_RST;
      volume_step            <= STEP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_PRESS:  press_cfg.min_press_ms <= cfg_data;
        REG_LONG_PRESS: press_cfg.long_hold_ms <= cfg_data;
        REG_STEP:       volume_step            <= cfg_data[VolW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op   <= op_t'(op);
      s1_up   <= up_down;
      s1_down <= down_down;
      s1_now  <= now_ms;
      s1_load <= load_value;
    end
  end

  tbvpc_button u_up (
    .clk     (clk),
    .rst     (rst),
    .en      (poll_en),
    .pressed (s1_up),
    .now_ms  (s1_now),
    .cfg     (press_cfg),
    .action  (up_act)
  );

  tbvpc_button u_down (
    .clk     (clk),
    .rst     (rst),
    .en      (poll_en),
    .pressed (s1_down),
    .now_ms  (s1_now),
    .cfg     (press_cfg),
    .action  (down_act)
  );

  tbvpc_volume u_volume (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .op          (s1_op),
    .load_value  (s1_load),
    .up_act      (up_act),
    .down_act    (down_act),
    .step        (volume_step),
    .volume_next (volume_next),
    .written     (written)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      volume         <= volume_next;
      volume_written <= written;
      // a load reports no button action
      up_action      <= (s1_op == OP_LOAD) ? ACT_NONE : up_act;
      down_action    <= (s1_op == OP_LOAD) ? ACT_NONE : down_act;
    end
  end

endmodule

@@ hw/rtl/tbvpc_button.sv @@
// press tracker for one button: held flag, press start time, long press fired
// computes the short or long action of a poll sample and updates on enable
// depends on tbvpc_pkg
module tbvpc_button (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       pressed,
  input  logic [tbvpc_pkg::TimeW-1:0] now_ms,
  input  tbvpc_pkg::press_cfg_t      cfg,
  output tbvpc_pkg::action_t         action
);
  import tbvpc_pkg::*;

  logic             held;
  logic [TimeW-1:0] start_time;
  logic             long_done;

  logic             held_next;
  logic [TimeW-1:0] start_time_next;
  logic             long_done_next;
  logic [TimeW-1:0] elapsed;

  // wraps modulo 2^32
  assign elapsed = now_ms - start_time;

  always_comb begin
    held_next       = held;
    start_time_next = start_time;
    long_done_next  = long_done;
    action          = ACT_NONE;
    if (pressed && !held) begin
      held_next       = 1'b1;
      start_time_next = now_ms;
      long_done_next  = 1'b0;
    end else if (pressed && !long_done &&
                 elapsed >= {{(TimeW-MsW){1'b0}}, cfg.long_hold_ms}) begin
      long_done_next = 1'b1;
      action         = ACT_LONG;
    end else if (!pressed && held) begin
      held_next = 1'b0;
      if (!long_done && elapsed >= {{(TimeW-MsW){1'b0}}, cfg.min_press_ms}) begin
        action = ACT_SHORT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= 1'b0;
      start_time <= '0;
      long_done  <= 1'b0;
    end else if (en) begin
      held       <= held_next;
      start_time <= start_time_next;
      long_done  <= long_done_next;
    end
  end

endmodule

@@ hw/rtl/tbvpc_volume.sv @@
// volume register with load clamp, long press set and saturating short steps
// up action applies first, down action applies to its result
// depends on tbvpc_pkg
module tbvpc_volume (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  tbvpc_pkg::op_t              op,
  input  logic signed [tbvpc_pkg::LoadW-1:0] load_value,
  input  tbvpc_pkg::action_t          up_act,
  input  tbvpc_pkg::action_t          down_act,
  input  logic [tbvpc_pkg::VolW-1:0]  step,
  output logic [tbvpc_pkg::VolW-1:0]  volume_next,
  output logic                        written
);
  import tbvpc_pkg::*;

  logic [VolW-1:0] volume_level;
  logic [VolW-1:0] load_clamped;
  logic [VolW-1:0] after_up;
  logic [VolW:0]   up_sum;

  always_comb begin
    if (load_value[LoadW-1]) begin
      load_clamped = VOL_MIN;
    end else if (load_value > $signed({1'b0, VOL_MAX})) begin
      load_clamped = VOL_MAX;
    end else begin
      load_clamped = load_value[VolW-1:0];
    end
  end

  assign up_sum = {1'b0, volume_level} + {1'b0, step};

  always_comb begin
    case (up_act)
      ACT_LONG:  after_up = VOL_MAX;
      ACT_SHORT: after_up = (up_sum > {1'b0, VOL_MAX}) ? VOL_MAX : up_sum[VolW-1:0];
      default:   after_up = volume_level;
    endcase
  end

  always_comb begin
    if (op == OP_LOAD) begin
      volume_next = load_clamped;
      written     = 1'b1;
    end else begin
      case (down_act)
        ACT_LONG:  volume_next = VOL_MIN;
        ACT_SHORT: volume_next = (step > after_up) ? VOL_MIN : after_up - step;
        default:   volume_next = after_up;
      endcase
      written = (up_act != ACT_NONE) || (down_act != ACT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_level <= VOLUME_RST;
    end else if (en) begin
      volume_level <= volume_next;
    end
  end

endmodule
